// ----- rtl/oae_pkg.sv -----
// Shared types and constants for the order-2 arithmetic encoder.
package oae_pkg;

    localparam int SYM_W       = 9;
    localparam int COUNT_W     = 32;
    localparam int FOLLOW_W    = 32;
    localparam int LIMIT_W     = 30;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;

    localparam int ALPHA       = 257;
    localparam int ROW_LEN     = 258;
    localparam int NCTX        = ALPHA * ALPHA;
    localparam int COUNT_DEPTH = NCTX * ROW_LEN;
    localparam int CTX_W       = $clog2(NCTX);
    localparam int ROW_ADDR_W  = $clog2(COUNT_DEPTH);

    localparam logic [SYM_W-1:0]   END_SYM     = SYM_W'(256);
    localparam logic [SYM_W-1:0]   TOTAL_IDX   = SYM_W'(257);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65535);

    localparam int DEF_CODE_BITS        = 32;
    localparam int DEF_TAIL_FOLLOW_BITS = 32;

    // register index (paddr[2])
    localparam logic REG_COUNT_LIMIT = 1'b0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BASE,
        S_RD_LO,
        S_RD_HI,
        S_RD_TOT,
        S_TOT,
        S_HI_GO,
        S_HI_WAIT,
        S_LO_GO,
        S_LO_WAIT,
        S_WALK,
        S_RENORM,
        S_EOM,
        S_FLUSH
    } oae_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

endpackage

// ----- rtl/oae_if.sv -----
// Symbol and result channel interfaces.
interface oae_sym_if;
    logic                      valid;
    logic                      ready;
    logic [oae_pkg::SYM_W-1:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface oae_res_if;
    logic                         valid;
    logic                         ready;
    logic                         out_bit;
    logic [oae_pkg::FOLLOW_W-1:0] follow_count;
    logic                         message_done;
    logic                         last;

    modport source (output valid, output out_bit, output follow_count,
                    output message_done, output last, input ready);
    modport sink   (input valid, input out_bit, input follow_count,
                    input message_done, input last, output ready);
endinterface

// ----- rtl/oae_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module oae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/oae_muldiv.sv -----
// Sequential (a * b) / d: shift-add multiply, then restoring divide.
module oae_muldiv #(
    parameter int CODE_BITS = oae_pkg::DEF_CODE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [CODE_BITS:0]            a,
    input  logic [oae_pkg::COUNT_W-1:0]   b,
    input  logic [oae_pkg::COUNT_W-1:0]   d,
    output logic                          done,
    output logic [CODE_BITS:0]            q
);
    import oae_pkg::*;

    localparam int AW = CODE_BITS + 1;
    localparam int P  = AW + COUNT_W;
    localparam int CW = $clog2(P + 1);

    md_state_t          state_reg, state_next;
    logic [P-1:0]       acc_reg, acc_next;
    logic [AW-1:0]      a_reg, a_next;
    logic [COUNT_W-1:0] b_reg, b_next;
    logic [COUNT_W-1:0] d_reg, d_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               done_reg, done_next;

    logic [COUNT_W:0]   rem_sh;
    logic               ge;

    assign rem_sh = {rem_reg, acc_reg[P-1]};
    assign ge     = rem_sh >= {1'b0, d_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE: if (start) state_next = MD_MUL;
            MD_MUL:  if (cnt_reg == CW'(COUNT_W - 1)) state_next = MD_DIV;
            MD_DIV:  if (cnt_reg == CW'(P - 1)) state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    a_next   = a;
                    b_next   = b;
                    d_next   = d;
                    acc_next = '0;
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            MD_MUL:
            begin
                acc_next = {acc_reg[P-2:0], 1'b0}
                         + (b_reg[COUNT_W-1] ? P'(a_reg) : P'(0));
                b_next   = {b_reg[COUNT_W-2:0], 1'b0};
                cnt_next = (cnt_reg == CW'(COUNT_W - 1)) ? '0 : cnt_reg + 1'b1;
            end
            MD_DIV:
            begin
                rem_next  = ge ? COUNT_W'(rem_sh - {1'b0, d_reg}) : rem_sh[COUNT_W-1:0];
                acc_next  = {acc_reg[P-2:0], ge};
                cnt_next  = cnt_reg + 1'b1;
                done_next = (cnt_reg == CW'(P - 1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign q    = acc_reg[AW-1:0];

endmodule

// ----- rtl/order2_arith_encoder.sv -----
// Order-2 context-adaptive arithmetic encoder, top level.
// Usage: symbols arrive on the sym channel (0..255 a byte, 256 end of message,
// larger codes are taken and dropped). Each decided code bit leaves on the res
// channel as out_bit plus follow_count inverted bits; last marks the final
// transfer caused by a symbol, message_done the closing transfer of a message.
// A symbol with no decided bit causes no transfer.
// Timing: one symbol at a time. Each symbol goes through the accepting cycle,
// the table reads and the row total check, two passes through the shared
// multiply/divide unit, the renormalization steps (up to CODE_BITS, plus a
// closing step), the end of message bit and a flush of the last transfer. The
// count update walk (up to 258 entries, one per cycle) starts with the first
// division and can outlast both passes.
// Reset and end of message: the row-valid memory is swept, one context per
// cycle, while sym.ready stays low; APB writes are taken.
// A stalled receiver holds the output register; a decided bit that finds the
// hold register full stops the encoder until the transfer completes.
// count_limit sits at APB address 0.
module order2_arith_encoder #(
    parameter int CODE_BITS        = oae_pkg::DEF_CODE_BITS,
    parameter int TAIL_FOLLOW_BITS = oae_pkg::DEF_TAIL_FOLLOW_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [oae_pkg::PADDR_W-1:0]      paddr,
    input  logic [oae_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [oae_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    oae_sym_if.sink                          sym,
    oae_res_if.source                        res
);
    import oae_pkg::*;

    localparam int W    = CODE_BITS;
    localparam int IT_W = $clog2(W + 1);
    localparam logic [W-1:0]       QUARTER = W'(1) << (W - 2);
    localparam logic [COUNT_W-1:0] QUARTER_C = COUNT_W'(1) << (W - 2);
    localparam logic [FOLLOW_W:0]  TAIL = (FOLLOW_W + 1)'(TAIL_FOLLOW_BITS);

    // control and state registers
    oae_state_t           state_reg, state_next;
    logic [CTX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [SYM_W-1:0]     sym_reg, sym_next;
    logic [CTX_W-1:0]     ctx_reg, ctx_next;
    logic [ROW_ADDR_W-1:0] base_reg, base_next;
    logic                 row_valid_reg, row_valid_next;
    logic [COUNT_W-1:0]   lo_c_reg, lo_c_next;
    logic [COUNT_W-1:0]   hi_c_reg, hi_c_next;
    logic [COUNT_W-1:0]   tot_reg, tot_next;
    logic                 upd_reg, upd_next;
    logic [W:0]           hi_q_reg, hi_q_next;
    logic [W-1:0]         low_reg, low_next;
    logic [W-1:0]         high_reg, high_next;
    logic [FOLLOW_W-1:0]  pending_reg, pending_next;
    logic [SYM_W-1:0]     prev_reg, prev_next;
    logic [SYM_W-1:0]     prev2_reg, prev2_next;
    logic [IT_W-1:0]      iter_reg, iter_next;
    logic                 walk_run_reg, walk_run_next;
    logic                 walk_init_reg, walk_init_next;
    logic [SYM_W-1:0]     walk_k_reg, walk_k_next;
    logic                 wb_valid_reg, wb_valid_next;
    logic [SYM_W-1:0]     wb_k_reg, wb_k_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic                 hold_bit_reg, hold_bit_next;
    logic [FOLLOW_W-1:0]  hold_follow_reg, hold_follow_next;
    logic                 hold_done_reg, hold_done_next;
    logic                 ov_reg, ov_next;
    logic                 o_bit_reg, o_bit_next;
    logic [FOLLOW_W-1:0]  o_follow_reg, o_follow_next;
    logic                 o_done_reg, o_done_next;
    logic                 o_last_reg, o_last_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;

    // memories
    logic                  cnt_we;
    logic [ROW_ADDR_W-1:0] cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0]    cnt_wdata, cnt_rdata;
    logic                  rv_we, rv_wdata, rv_rdata;
    logic [CTX_W-1:0]      rv_waddr, rv_raddr;

    // divider
    logic                  md_start, md_done;
    logic [W:0]            md_a, md_q;
    logic [COUNT_W-1:0]    md_b, md_d;

    // other combinational
    logic                  eom;
    logic                  out_free, emit_ok;
    logic                  rn_emit0, rn_emit1, rn_follow, rn_brk, rn_end;
    logic [W-1:0]          low_s, high_s;
    logic [COUNT_W-1:0]    lim, tot_raw, fetch_val;
    logic [FOLLOW_W:0]     tail_sum;
    logic                  apb_wr, walk_busy;
    logic [CTX_W-1:0]      ctx_calc;

    oae_ram #(.WIDTH(COUNT_W), .DEPTH(COUNT_DEPTH)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    oae_ram #(.WIDTH(1), .DEPTH(NCTX)) u_row_valid_ram (
        .clk   (clk),
        .we    (rv_we),
        .waddr (rv_waddr),
        .wdata (rv_wdata),
        .raddr (rv_raddr),
        .rdata (rv_rdata)
    );

    oae_muldiv #(.CODE_BITS(CODE_BITS)) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (md_a),
        .b     (md_b),
        .d     (md_d),
        .done  (md_done),
        .q     (md_q)
    );

    assign eom       = (sym_reg == END_SYM);
    assign out_free  = !ov_reg || res.ready;
    assign emit_ok   = !hold_valid_reg || out_free;
    assign walk_busy = walk_run_reg || wb_valid_reg;

    // context of the two previous symbols: prev2 * 257 + prev
    assign ctx_calc = {prev2_reg, 8'b0} + CTX_W'(prev2_reg) + CTX_W'(prev_reg);

    // an untouched row reads as the ramp k
    assign fetch_val = row_valid_reg ? cnt_rdata : COUNT_W'(0);
    assign tot_raw   = row_valid_reg ? cnt_rdata : COUNT_W'(TOTAL_IDX);
    assign lim       = (COUNT_W'(limit_reg) > QUARTER_C) ? QUARTER_C : COUNT_W'(limit_reg);

    // renormalization step classification
    assign rn_emit0  = !high_reg[W-1];
    assign rn_emit1  = high_reg[W-1] && low_reg[W-1];
    assign rn_follow = high_reg[W-1] && !low_reg[W-1]
                       && (low_reg[W-1:W-2] == 2'b01) && (high_reg[W-1:W-2] == 2'b10);
    assign rn_brk    = !rn_emit0 && !rn_emit1 && !rn_follow;
    assign rn_end    = (iter_reg == IT_W'(W)) || rn_brk;

    always_comb
    begin
        low_s  = low_reg;
        high_s = high_reg;
        if (rn_emit1)
        begin
            low_s[W-1]  = 1'b0;
            high_s[W-1] = 1'b0;
        end
        else if (rn_follow)
        begin
            low_s  = low_reg - QUARTER;
            high_s = high_reg - QUARTER;
        end
    end

    assign tail_sum = {1'b0, pending_reg} + TAIL;

    // divider operands: range times the symbol's bound over the row total
    assign md_a     = {1'b0, high_reg} - {1'b0, low_reg} + (W + 1)'(1);
    assign md_b     = (state_reg == S_HI_GO) ? hi_c_reg : lo_c_reg;
    assign md_d     = (tot_reg == '0) ? COUNT_W'(1) : tot_reg;
    assign md_start = (state_reg == S_HI_GO) || (state_reg == S_LO_GO);

    // APB
    assign apb_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_COUNT_LIMIT);
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_COUNT_LIMIT)
                  ? APB_DATA_W'(limit_reg) : APB_DATA_W'(0);

    assign sym.ready = (state_reg == S_IDLE);

    assign res.valid        = ov_reg;
    assign res.out_bit      = o_bit_reg;
    assign res.follow_count = o_follow_reg;
    assign res.message_done = o_done_reg;
    assign res.last         = o_last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:   if (clr_cnt_reg == CTX_W'(NCTX - 1)) state_next = S_IDLE;
            S_IDLE:    if (sym.valid && (sym.symbol <= END_SYM)) state_next = S_BASE;
            S_BASE:    state_next = S_RD_LO;
            S_RD_LO:   state_next = S_RD_HI;
            S_RD_HI:   state_next = S_RD_TOT;
            S_RD_TOT:  state_next = S_TOT;
            S_TOT:     state_next = S_HI_GO;
            S_HI_GO:   state_next = S_HI_WAIT;
            S_HI_WAIT: if (md_done) state_next = S_LO_GO;
            S_LO_GO:   state_next = S_LO_WAIT;
            S_LO_WAIT: if (md_done) state_next = S_WALK;
            S_WALK:    if (!walk_busy) state_next = S_RENORM;
            S_RENORM:  if (rn_end) state_next = eom ? S_EOM : S_FLUSH;
            S_EOM:     if (emit_ok) state_next = S_FLUSH;
            S_FLUSH:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    state_next = eom ? S_CLEAR : S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_cnt_next     = clr_cnt_reg;
        sym_next         = sym_reg;
        ctx_next         = ctx_reg;
        base_next        = base_reg;
        row_valid_next   = row_valid_reg;
        lo_c_next        = lo_c_reg;
        hi_c_next        = hi_c_reg;
        tot_next         = tot_reg;
        upd_next         = upd_reg;
        hi_q_next        = hi_q_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        pending_next     = pending_reg;
        prev_next        = prev_reg;
        prev2_next       = prev2_reg;
        iter_next        = iter_reg;
        walk_run_next    = walk_run_reg;
        walk_init_next   = walk_init_reg;
        walk_k_next      = walk_k_reg;
        wb_valid_next    = 1'b0;
        wb_k_next        = wb_k_reg;
        hold_valid_next  = hold_valid_reg;
        hold_bit_next    = hold_bit_reg;
        hold_follow_next = hold_follow_reg;
        hold_done_next   = hold_done_reg;
        ov_next          = ov_reg && !res.ready;
        o_bit_next       = o_bit_reg;
        o_follow_next    = o_follow_reg;
        o_done_next      = o_done_reg;
        o_last_next      = o_last_reg;
        limit_next       = apb_wr ? pwdata[LIMIT_W-1:0] : limit_reg;

        cnt_we    = 1'b0;
        cnt_waddr = base_reg + ROW_ADDR_W'(walk_k_reg);
        cnt_wdata = COUNT_W'(walk_k_reg)
                  + ((upd_reg && (walk_k_reg > sym_reg)) ? COUNT_W'(1) : COUNT_W'(0));
        cnt_raddr = base_reg + ROW_ADDR_W'(walk_k_reg);
        rv_we     = 1'b0;
        rv_waddr  = ctx_reg;
        rv_wdata  = 1'b1;
        rv_raddr  = ctx_reg;

        // count update walk: ramp fill of a fresh row, or read-increment-write
        if (walk_run_reg)
        begin
            if (walk_init_reg)
            begin
                cnt_we = 1'b1;
            end
            else
            begin
                wb_valid_next = 1'b1;
                wb_k_next     = walk_k_reg;
            end
            if (walk_k_reg == TOTAL_IDX)
            begin
                walk_run_next = 1'b0;
            end
            else
            begin
                walk_k_next = walk_k_reg + 1'b1;
            end
        end
        if (wb_valid_reg)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = base_reg + ROW_ADDR_W'(wb_k_reg);
            cnt_wdata = cnt_rdata + COUNT_W'(1);
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                rv_we        = 1'b1;
                rv_waddr     = clr_cnt_reg;
                rv_wdata     = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (sym.valid)
                begin
                    sym_next = sym.symbol;
                    ctx_next = ctx_calc;
                end
            end
            S_BASE:
            begin
                base_next = {ctx_reg, 8'b0} + ROW_ADDR_W'({ctx_reg, 1'b0});
            end
            S_RD_LO:
            begin
                row_valid_next = rv_rdata;
                cnt_raddr      = base_reg + ROW_ADDR_W'(sym_reg);
            end
            S_RD_HI:
            begin
                cnt_raddr = base_reg + ROW_ADDR_W'(sym_reg) + ROW_ADDR_W'(1);
                lo_c_next = row_valid_reg ? fetch_val : COUNT_W'(sym_reg);
            end
            S_RD_TOT:
            begin
                cnt_raddr = base_reg + ROW_ADDR_W'(TOTAL_IDX);
                hi_c_next = row_valid_reg ? fetch_val : COUNT_W'(sym_reg) + COUNT_W'(1);
            end
            S_TOT:
            begin
                tot_next   = tot_raw;
                upd_next   = tot_raw < lim;
                rv_we      = !row_valid_reg;
                prev2_next = prev_reg;
                prev_next  = sym_reg;
            end
            S_HI_GO:
            begin
                if (!row_valid_reg)
                begin
                    walk_run_next  = 1'b1;
                    walk_init_next = 1'b1;
                    walk_k_next    = '0;
                end
                else if (upd_reg)
                begin
                    walk_run_next  = 1'b1;
                    walk_init_next = 1'b0;
                    walk_k_next    = sym_reg + 1'b1;
                end
            end
            S_HI_WAIT:
            begin
                if (md_done)
                begin
                    hi_q_next = md_q;
                end
            end
            S_LO_GO: ;
            S_LO_WAIT:
            begin
                if (md_done)
                begin
                    high_next = W'({1'b0, low_reg} + hi_q_reg - (W + 1)'(1));
                    low_next  = W'({1'b0, low_reg} + md_q);
                    iter_next = '0;
                end
            end
            S_WALK: ;
            S_RENORM:
            begin
                if (!rn_end && (rn_follow || emit_ok))
                begin
                    if (rn_follow)
                    begin
                        if (pending_reg != '1)
                        begin
                            pending_next = pending_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (hold_valid_reg)
                        begin
                            ov_next       = 1'b1;
                            o_bit_next    = hold_bit_reg;
                            o_follow_next = hold_follow_reg;
                            o_done_next   = hold_done_reg;
                            o_last_next   = 1'b0;
                        end
                        hold_valid_next  = 1'b1;
                        hold_bit_next    = rn_emit1;
                        hold_follow_next = pending_reg;
                        hold_done_next   = 1'b0;
                        pending_next     = '0;
                    end
                    high_next = {high_s[W-2:0], 1'b1};
                    low_next  = {low_s[W-2:0], 1'b0};
                    iter_next = iter_reg + 1'b1;
                end
            end
            S_EOM:
            begin
                if (emit_ok)
                begin
                    if (hold_valid_reg)
                    begin
                        ov_next       = 1'b1;
                        o_bit_next    = hold_bit_reg;
                        o_follow_next = hold_follow_reg;
                        o_done_next   = hold_done_reg;
                        o_last_next   = 1'b0;
                    end
                    hold_valid_next  = 1'b1;
                    hold_bit_next    = (low_reg[W-1:W-2] != 2'b00);
                    hold_follow_next = tail_sum[FOLLOW_W] ? '1 : tail_sum[FOLLOW_W-1:0];
                    hold_done_next   = 1'b1;
                    // back to the reset interval and context
                    low_next     = '0;
                    high_next    = '1;
                    pending_next = '0;
                    prev_next    = END_SYM;
                    prev2_next   = END_SYM;
                end
            end
            S_FLUSH:
            begin
                if (hold_valid_reg && out_free)
                begin
                    ov_next         = 1'b1;
                    o_bit_next      = hold_bit_reg;
                    o_follow_next   = hold_follow_reg;
                    o_done_next     = hold_done_reg;
                    o_last_next     = 1'b1;
                    hold_valid_next = 1'b0;
                end
                clr_cnt_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            low_reg        <= '0;
            high_reg       <= '1;
            pending_reg    <= '0;
            prev_reg       <= END_SYM;
            prev2_reg      <= END_SYM;
            iter_reg       <= '0;
            walk_run_reg   <= 1'b0;
            walk_init_reg  <= 1'b0;
            wb_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            ov_reg         <= 1'b0;
            limit_reg      <= LIMIT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            pending_reg    <= pending_next;
            prev_reg       <= prev_next;
            prev2_reg      <= prev2_next;
            iter_reg       <= iter_next;
            walk_run_reg   <= walk_run_next;
            walk_init_reg  <= walk_init_next;
            wb_valid_reg   <= wb_valid_next;
            hold_valid_reg <= hold_valid_next;
            ov_reg         <= ov_next;
            limit_reg      <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg         <= sym_next;
        ctx_reg         <= ctx_next;
        base_reg        <= base_next;
        row_valid_reg   <= row_valid_next;
        lo_c_reg        <= lo_c_next;
        hi_c_reg        <= hi_c_next;
        tot_reg         <= tot_next;
        upd_reg         <= upd_next;
        hi_q_reg        <= hi_q_next;
        walk_k_reg      <= walk_k_next;
        wb_k_reg        <= wb_k_next;
        hold_bit_reg    <= hold_bit_next;
        hold_follow_reg <= hold_follow_next;
        hold_done_reg   <= hold_done_next;
        o_bit_reg       <= o_bit_next;
        o_follow_reg    <= o_follow_next;
        o_done_reg      <= o_done_next;
        o_last_reg      <= o_last_next;
    end

endmodule
